### design/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// shared types and constants of the button debounce and hold event core
// ----------------------------------------------------------------------------
`default_nettype none

package bdh_pkg;

   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned CFG_WIDTH       = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned MASK_WIDTH      = 3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TIME = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TIME     = 4'd1;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TIME_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] HOLD_TIME_RESET     = 16'd500;

   // consume mask bits
   localparam int unsigned CONSUME_PRESS   = 0;
   localparam int unsigned CONSUME_HOLD    = 1;
   localparam int unsigned CONSUME_RELEASE = 2;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  pin_level;
      logic [MASK_WIDTH-1:0] consume_mask;
   } req_type;

   typedef struct packed {
      logic pressed;
      logic held;
      logic press_event;
      logic hold_event;
      logic release_event;
   } rsp_type;

   typedef struct packed {
      logic hold_event;
      logic held;
      logic release_event;
      logic press_event;
      logic was_pressed;
      logic pressed;
   } status_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] settle_ms;
      logic [CFG_WIDTH-1:0] hold_time;
   } cfg_type;

endpackage

`default_nettype wire

### design/button_debounce_hold_events_core.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_events_core
// path: a req beat passes the input register, then the result register, to rsp
// throughput: one beat per cycle while rsp_stall does not hold a full result register
// reset: synchronous, clears status, change stamp and valid flags;
//        the debounce window returns to 50 ms and hold_time to 500 ms
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_hold_events_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // input beats
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  bdh_pkg::req_type                     req_data,
   // result beats
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output bdh_pkg::rsp_type                     rsp_data,
   // register writes
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [bdh_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [bdh_pkg::CFG_WIDTH-1:0]        csr_data
);
   import bdh_pkg::*;

   // input register
   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_type               in_data_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;

   // button state carried between beats
   status_type            status_ff;
   logic [TIME_WIDTH-1:0] last_change_ff;

   cfg_type               cfg;
   status_type            status_next;
   logic                  change_load;
   rsp_type               rsp_next;
   logic                  req_accept;
   logic                  advance;

   // config writes are always taken
   assign csr_ready = 1'b1;

   bdh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // status update works on the beat held in the input register
   bdh_update u_update (
      .req         (in_data_ff),
      .cfg         (cfg),
      .status      (status_ff),
      .last_change (last_change_ff),
      .status_next (status_next),
      .change_load (change_load),
      .rsp         (rsp_next)
   );

   // a beat moves on when the result register is free or being emptied
   assign advance    = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   assign in_valid_in  = req_accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         status_ff      <= '0;
         last_change_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // state commits only as the beat moves to the result register
         if (advance) begin
            status_ff <= status_next;
            if (change_load) begin
               last_change_ff <= in_data_ff.now_ms;
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### design/bdh_csr.sv
// ----------------------------------------------------------------------------
// bdh_csr
// debounce and hold time registers with index decode
// ----------------------------------------------------------------------------
`default_nettype none

module bdh_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write,
   input  wire  [bdh_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [bdh_pkg::CFG_WIDTH-1:0]         csr_data,
   output bdh_pkg::cfg_type                      cfg
);
   import bdh_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         // unknown indexes are dropped
         unique case (csr_index)
            CSR_DEBOUNCE_TIME: cfg_in.settle_ms = csr_data;
            CSR_HOLD_TIME:     cfg_in.hold_time = csr_data;
            default:           cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ms <= DEBOUNCE_TIME_RESET;
         cfg_ff.hold_time <= HOLD_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### design/bdh_update.sv
// ----------------------------------------------------------------------------
// bdh_update
// one-beat debounce, edge and hold update of the button status
// ----------------------------------------------------------------------------
`default_nettype none

module bdh_update (
   input  bdh_pkg::req_type                  req,
   input  bdh_pkg::cfg_type                  cfg,
   input  bdh_pkg::status_type               status,
   input  wire  [bdh_pkg::TIME_WIDTH-1:0]    last_change,
   output bdh_pkg::status_type               status_next,
   output logic                              change_load,
   output bdh_pkg::rsp_type                  rsp
);
   import bdh_pkg::*;

   logic [TIME_WIDTH-1:0] elapsed;
   logic                  settled;
   logic                  hold_reached;
   logic                  new_press;
   status_type            s;

   assign elapsed = req.now_ms - last_change;
   assign settled = elapsed > {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.settle_ms};

   always_comb begin
      s           = status;
      change_load = 1'b0;
      new_press   = 1'b0;
      if (settled) begin
         s.pressed = ~req.pin_level;
      end
      priority if (s.was_pressed && !s.pressed) begin
         // release wipes everything but the release event
         s               = '0;
         s.release_event = 1'b1;
         change_load     = 1'b1;
      end else if (!s.was_pressed && s.pressed) begin
         s             = '0;
         s.pressed     = 1'b1;
         s.was_pressed = 1'b1;
         s.press_event = 1'b1;
         change_load   = 1'b1;
         new_press     = 1'b1;
      end else begin
         s = s;
      end
      // on a fresh press the elapsed time is zero
      hold_reached = new_press ? (cfg.hold_time == '0)
                               : (elapsed >= {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.hold_time});
      if (s.pressed && !s.held && hold_reached) begin
         s.held       = 1'b1;
         s.hold_event = 1'b1;
      end
   end

   assign rsp.pressed       = s.pressed;
   assign rsp.held          = s.held;
   assign rsp.press_event   = s.press_event;
   assign rsp.hold_event    = s.hold_event;
   assign rsp.release_event = s.release_event;

   always_comb begin
      status_next = s;
      if (req.consume_mask[CONSUME_PRESS])   status_next.press_event   = 1'b0;
      if (req.consume_mask[CONSUME_HOLD])    status_next.hold_event    = 1'b0;
      if (req.consume_mask[CONSUME_RELEASE]) status_next.release_event = 1'b0;
   end

endmodule

`default_nettype wire

### test/button_debounce_hold_events_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_hold_events_core_test
// self-checking bench for the debounce and long-press core: a queue-fed
// driver offers button samples, a predictor tracks the debounced status and
// a monitor compares every report beat with the expected one, across several
// debounce and hold settings and under random and long back-pressure
// ----------------------------------------------------------------------------

module button_debounce_hold_events_core_test;

   import bdh_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int LATENCY_CYCLES = 2;
   localparam int DRAIN_CYCLES   = LATENCY_CYCLES + 4;
   localparam int HOLDOFF_CYCLES = 120;
   localparam int MISMATCH_SHOWN = 10;
   localparam int WATCHDOG_NS    = 2000000;

   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_INDEX = 4'hE;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // dut inputs, all driven from time zero
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_data  = '0;

   // samples waiting to be offered, and reports waiting to come back
   req_type button_samples_q[$];
   rsp_type expected_reports_q[$];

   // predictor copy of the core state and registers
   status_type            status_model      = '0;
   logic [TIME_WIDTH-1:0] last_change_model = '0;
   logic [CFG_WIDTH-1:0]  debounce_model    = DEBOUNCE_TIME_RESET;
   logic [CFG_WIDTH-1:0]  hold_model        = HOLD_TIME_RESET;

   // idling and hold-off control; the sequence writes the settings and requests at falling edges
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned holdoff_requests  = 0;
   int unsigned holdoffs_served   = 0;
   int unsigned holdoff_left      = 0;

   // random button scenario state
   logic [TIME_WIDTH-1:0] stim_now_ms   = '0;
   logic                  stim_level    = 1'b1;
   int unsigned           stim_run_left = 0;

   // bookkeeping
   int unsigned beats_accepted  = 0;
   int unsigned reports_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned stalled_offers  = 0;
   int unsigned settings_used   = 0;
   int unsigned press_seen      = 0;
   int unsigned hold_seen       = 0;
   int unsigned release_seen    = 0;

   button_debounce_hold_events_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor: one accepted sample in, one expected report out
   // ------------------------------------------------------------------------
   function automatic void predict_button_report(input req_type sample);
      logic [TIME_WIDTH-1:0] elapsed;
      status_type            s;
      rsp_type               report;
      elapsed = sample.now_ms - last_change_model;   // wraps modulo 2^32
      s = status_model;
      // pin only looked at once the debounce window has passed
      if (elapsed > TIME_WIDTH'(debounce_model))
         s.pressed = ~sample.pin_level;
      if (s.was_pressed && !s.pressed) begin
         // release wipes everything, pending press and hold events too
         s = '0;
         s.release_event = 1'b1;
         last_change_model = sample.now_ms;
      end else if (s.pressed && !s.was_pressed) begin
         // new press drops any old event and restarts the hold timer
         s = '0;
         s.pressed     = 1'b1;
         s.was_pressed = 1'b1;
         s.press_event = 1'b1;
         last_change_model = sample.now_ms;
         elapsed = '0;
      end
      // zero hold time flags hold on the press beat itself
      if (s.pressed && !s.held && elapsed >= TIME_WIDTH'(hold_model)) begin
         s.held       = 1'b1;
         s.hold_event = 1'b1;
      end
      report.pressed       = s.pressed;
      report.held          = s.held;
      report.press_event   = s.press_event;
      report.hold_event    = s.hold_event;
      report.release_event = s.release_event;
      expected_reports_q.push_back(report);
      // events are consumed after being reported
      if (sample.consume_mask[CONSUME_PRESS])   s.press_event   = 1'b0;
      if (sample.consume_mask[CONSUME_HOLD])    s.hold_event    = 1'b0;
      if (sample.consume_mask[CONSUME_RELEASE]) s.release_event = 1'b0;
      status_model = s;
   endfunction

   // ------------------------------------------------------------------------
   // driver: offers queued samples, keeps a stalled beat untouched
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : sample_driver
      logic took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            predict_button_report(req_data);
            beats_accepted++;
         end
         if (req_valid && req_stall)
            stalled_offers++;
         // only move on once the current beat is gone
         if (!req_valid || took) begin
            if (button_samples_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data  <= button_samples_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver stall: random idling plus long hold-offs on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall       <= 1'b0;
         holdoff_left    <= 0;
         holdoffs_served <= 0;
      end else if (holdoffs_served != holdoff_requests) begin
         holdoffs_served <= holdoffs_served + 1;
         holdoff_left    <= HOLDOFF_CYCLES;
         rsp_stall       <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: each report beat against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : report_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         press_seen   += 32'(rsp_data.press_event);
         hold_seen    += 32'(rsp_data.hold_event);
         release_seen += 32'(rsp_data.release_event);
         if (expected_reports_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN)
               $display("[%0t] report beat with nothing expected: p%b h%b pe%b he%b re%b",
                        $time, rsp_data.pressed, rsp_data.held, rsp_data.press_event,
                        rsp_data.hold_event, rsp_data.release_event);
         end else begin
            want = expected_reports_q.pop_front();
            if (rsp_data.pressed       !== want.pressed     ||
                rsp_data.held          !== want.held        ||
                rsp_data.press_event   !== want.press_event ||
                rsp_data.hold_event    !== want.hold_event  ||
                rsp_data.release_event !== want.release_event) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN)
                  $display({"[%0t] report %0d: expected p%b h%b pe%b he%b re%b,",
                            " got p%b h%b pe%b he%b re%b"},
                           $time, reports_checked, want.pressed, want.held,
                           want.press_event, want.hold_event, want.release_event,
                           rsp_data.pressed, rsp_data.held, rsp_data.press_event,
                           rsp_data.hold_event, rsp_data.release_event);
            end
            reports_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CFG_WIDTH-1:0]       value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DEBOUNCE_TIME)
         debounce_model = value;
      else if (idx == CSR_HOLD_TIME)
         hold_model = value;
   endtask

   task automatic apply_setting(input logic [CFG_WIDTH-1:0] debounce_ms,
                                input logic [CFG_WIDTH-1:0] hold_ms);
      write_register(CSR_DEBOUNCE_TIME, debounce_ms);
      write_register(CSR_HOLD_TIME, hold_ms);
      settings_used++;
   endtask

   task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
      @(negedge clock);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   // sender pause: nothing left to send and every report back
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (button_samples_q.size() != 0 || req_valid || expected_reports_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_sample(input logic [TIME_WIDTH-1:0] now_ms, input logic pin,
                               input logic [MASK_WIDTH-1:0] mask);
      req_type sample;
      sample.now_ms       = now_ms;
      sample.pin_level    = pin;
      sample.consume_mask = mask;
      button_samples_q.push_back(sample);
   endtask

   // time steps scaled to the current windows so thresholds get hit
   function automatic logic [TIME_WIDTH-1:0] pick_gap();
      int unsigned pick;
      int unsigned deb;
      int unsigned hld;
      pick = $urandom_range(99);
      deb  = 32'(debounce_model);
      hld  = 32'(hold_model);
      if (pick < 40)      return $urandom_range(deb / 4 + 1);
      else if (pick < 65) return deb + $urandom_range(2);
      else if (pick < 85) return $urandom_range(hld / 3 + 2);
      else if (pick < 95) return $urandom_range(2 * hld + 2);
      else                return $urandom;
   endfunction

   // presses and releases with contact bounce, plus some pure noise
   function automatic req_type make_button_beat();
      req_type beat;
      if ($urandom_range(99) < 8) begin
         beat.now_ms       = $urandom;
         beat.pin_level    = 1'($urandom_range(1));
         beat.consume_mask = 3'($urandom_range(7));
         return beat;
      end
      if (stim_run_left == 0) begin
         stim_level    = ~stim_level;
         stim_run_left = $urandom_range(10, 2);
      end
      stim_run_left--;
      stim_now_ms      += pick_gap();
      beat.now_ms       = stim_now_ms;
      beat.pin_level    = ($urandom_range(99) < 12) ? ~stim_level : stim_level;
      beat.consume_mask = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7));
      return beat;
   endfunction

   task automatic queue_random_samples(input int unsigned count);
      repeat (count) button_samples_q.push_back(make_button_beat());
   endtask

   // long receiver hold-off once some beats are flowing
   task automatic request_holdoff();
      int unsigned mark;
      mark = beats_accepted;
      wait (beats_accepted >= mark + 20);
      @(negedge clock);
      holdoff_requests++;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset values 50 / 500 written back explicitly
      apply_setting(DEBOUNCE_TIME_RESET, HOLD_TIME_RESET);
      set_idling(20, 73);

      // directed walk through the basic behavior
      queue_sample(32'd0, 1'b1, 3'd0);            // idle, nothing sampled
      queue_sample(32'd30, 1'b0, 3'd0);           // inside debounce window
      queue_sample(32'd51, 1'b0, 3'd0);           // press
      queue_sample(32'd80, 1'b1, 3'd1);           // bounce ignored, consume press
      queue_sample(32'd551, 1'b0, 3'd0);          // hold reached exactly
      queue_sample(32'd600, 1'b0, 3'd2);          // consume hold
      queue_sample(32'd700, 1'b1, 3'd0);          // release
      queue_sample(32'd720, 1'b0, 3'd4);          // bounce after release
      queue_sample(32'hFFFF_FFF0, 1'b0, 3'd7);    // press near the top of time
      queue_sample(32'h0000_0010, 1'b0, 3'd0);    // wrapped, still short
      queue_sample(32'h0000_0300, 1'b0, 3'd7);    // hold across the wrap
      queue_sample(32'hFFFF_FFFF, 1'b1, 3'd0);    // pin high inside the window, ignored
      queue_sample(32'h0000_003B, 1'b0, 3'd0);    // still pressed, no new event
      queue_sample(32'd110, 1'b1, 3'd0);          // release
      queue_sample(32'd200, 1'b1, 3'd4);          // consume release
      wait_until_quiet();

      // both windows at zero: hold flagged on the press beat
      apply_setting(16'd0, 16'd0);
      queue_sample(32'd1000, 1'b0, 3'd0);
      queue_sample(32'd1000, 1'b1, 3'd0);         // no time passed, ignored
      queue_sample(32'd1001, 1'b1, 3'd7);
      stim_now_ms = 32'd2000;
      queue_random_samples(150);
      wait_until_quiet();

      // both windows at max, time stamps running through the wrap
      apply_setting(16'hFFFF, 16'hFFFF);
      set_idling(73, 20);
      stim_now_ms = 32'hFFFF_8000;
      queue_random_samples(150);
      wait_until_quiet();

      // short windows, long receiver hold-off to back up the core
      apply_setting(16'd10, 16'd40);
      queue_random_samples(200);
      request_holdoff();
      wait_until_quiet();

      // random windows, no idling on either side
      apply_setting(16'($urandom_range(200)), 16'($urandom_range(1000)));
      set_idling(0, 0);
      queue_random_samples(200);
      request_holdoff();
      wait_until_quiet();

      // write to a hole in the map must change nothing
      write_register(CSR_UNMAPPED_INDEX, 16'hFFFF);
      apply_setting(16'd2, 16'hFFFF);
      queue_random_samples(200);
      wait_until_quiet();

      $display("covered %0d sample beats and %0d report beats over %0d window settings",
               beats_accepted, reports_checked, settings_used);
      $display("events reported: %0d press, %0d hold, %0d release; input stalled %0d cycles",
               press_seen, hold_seen, release_seen, stalled_offers);
      if (mismatch_count == 0 && expected_reports_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // hard stop in case the core hangs
   initial begin
      #(WATCHDOG_NS);
      $display("watchdog expired with %0d reports outstanding", expected_reports_q.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

### button_debounce_hold_events_core.f
design/bdh_pkg.sv
design/bdh_csr.sv
design/bdh_update.sv
design/button_debounce_hold_events_core.sv
test/button_debounce_hold_events_core_test.sv
